// File: hw/rtl/pinned_fifo_retention_table_assert.svh
// Assertion macros shared by the retention table checker.
`ifndef PINNED_FIFO_RETENTION_TABLE_ASSERT_SVH
`define PINNED_FIFO_RETENTION_TABLE_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PFRT_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pfrt assertion failed");

// Concurrent assertion on the block clock and reset.
`define PFRT_ASSERT(label, prop) `PFRT_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// File: hw/rtl/pfrt_pkg.sv
// Package of the retention table: sizes, constants, payload and control types.
`default_nettype none

package pfrt_pkg;

  // Table geometry.
  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned FRAME_BITS  = 20;
  localparam int unsigned DEPTH       = MAX_ENTRIES + 1;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned LIMIT_W     = $clog2(MAX_ENTRIES + 1);

  // Field widths.
  localparam int unsigned ID_W       = 64;
  localparam int unsigned PROG_W     = 14;
  localparam int unsigned SUMM_W     = 16;
  localparam int unsigned BUDGET_W   = 16;
  localparam int unsigned LIMIT_IN_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MIB_SHIFT  = 20;

  // Size accumulator wide enough for the budget and for a full table.
  localparam int unsigned SIZE_W = (FRAME_BITS + 24 > 38) ? FRAME_BITS + 24 : 38;

  // Size estimate constants, in bytes.
  localparam int unsigned BASE_BYTES    = 256;
  localparam int unsigned SUMMARY_BYTES = 160;
  localparam int unsigned RECORD_BYTES  = 64;
  localparam int unsigned FRAME_BYTES   = 104;

  localparam int unsigned MIN_KEPT     = 2;
  localparam int unsigned PROGRESS_MAX = 10000;

  // Register reset values.
  localparam int unsigned LIMIT_RESET  = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
  localparam int unsigned BUDGET_RESET = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_MB   = 1'b1;

  // Mode codes of an input request.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TRIM   = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [ID_W-1:0]       record_id;
    logic [PROG_W-1:0]     progress;
    logic [FRAME_BITS-1:0] frame_count;
    logic [SUMM_W-1:0]     summary_count;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] evicted_id;
    logic            last;
  } out_item_t;

  // One stored record.
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [PROG_W-1:0]     progress;
    logic [FRAME_BITS-1:0] frames;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Control of the scan unit.
  typedef struct packed {
    logic             start;
    logic             en;
    logic [IDX_W-1:0] idx;
  } scan_ctrl_t;

  // Results of one pass of the scan unit.
  typedef struct packed {
    logic [SIZE_W-1:0]      total;
    logic [IDX_W-1:0]       newest_idx;
    logic [IDX_W-1:0]       best_idx;
    logic                   dup;
    logic [2:0][ID_W-1:0]   head_id;
  } scan_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_DECIDE,
    ST_PUSH_MID,
    ST_COMPACT,
    ST_PUSH_LAST
  } state_e;

  typedef enum logic {
    KIND_DUP,
    KIND_TRIM
  } scan_kind_e;

endpackage

`default_nettype wire

// File: hw/rtl/pfrt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module pfrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pfrt_scan_unit.sv
// Scan unit: takes one record per cycle while enabled; accumulates size, newest, best, duplicate and head ids.
`default_nettype none

module pfrt_scan_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pfrt_pkg::scan_ctrl_t       ctrl_i,
  input  wire logic [pfrt_pkg::SUMM_W-1:0] summaries_i,
  input  wire logic [pfrt_pkg::ID_W-1:0]  probe_id_i,
  input  wire pfrt_pkg::entry_t           entry_i,
  output pfrt_pkg::scan_res_t             res_o
);

  import pfrt_pkg::*;

  localparam int unsigned FPROD_W = FRAME_BITS + 7;
  localparam int unsigned SPROD_W = SUMM_W + 8;

  logic [SIZE_W-1:0]    total_q, total_d;
  logic [IDX_W-1:0]     newest_idx_q, newest_idx_d;
  logic [ID_W-1:0]      newest_id_q, newest_id_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [ID_W-1:0]      best_id_q, best_id_d;
  logic [PROG_W-1:0]    best_prog_q, best_prog_d;
  logic                 dup_q, dup_d;
  logic [2:0][ID_W-1:0] head_q, head_d;
  logic [FPROD_W-1:0]   frame_bytes;
  logic [SPROD_W-1:0]   summ_bytes;
  logic                 first;

  // Constant-coefficient products of the size estimate.
  assign frame_bytes = FPROD_W'(entry_i.frames) * FPROD_W'(FRAME_BYTES);
  assign summ_bytes  = SPROD_W'(summaries_i) * SPROD_W'(SUMMARY_BYTES);
  assign first       = (ctrl_i.idx == '0);

  // One step of the pass.
  always_comb begin
    total_d      = total_q;
    newest_idx_d = newest_idx_q;
    newest_id_d  = newest_id_q;
    best_idx_d   = best_idx_q;
    best_id_d    = best_id_q;
    best_prog_d  = best_prog_q;
    dup_d        = dup_q;
    head_d       = head_q;
    if (ctrl_i.start) begin
      total_d = SIZE_W'(BASE_BYTES) + SIZE_W'(summ_bytes);
      dup_d   = 1'b0;
    end else if (ctrl_i.en) begin
      total_d = total_q + SIZE_W'(RECORD_BYTES) + SIZE_W'(frame_bytes);
      if (first || (entry_i.id > newest_id_q)) begin
        newest_idx_d = ctrl_i.idx;
        newest_id_d  = entry_i.id;
      end
      // Best progress; equal progress goes to the larger id.
      if (first || (entry_i.progress > best_prog_q) ||
          ((entry_i.progress == best_prog_q) && (entry_i.id > best_id_q))) begin
        best_idx_d  = ctrl_i.idx;
        best_id_d   = entry_i.id;
        best_prog_d = entry_i.progress;
      end
      if (entry_i.id == probe_id_i) begin
        dup_d = 1'b1;
      end
      // Keep the three oldest ids for the victim choice.
      if (ctrl_i.idx == IDX_W'(0)) begin
        head_d[0] = entry_i.id;
      end
      if (ctrl_i.idx == IDX_W'(1)) begin
        head_d[1] = entry_i.id;
      end
      if (ctrl_i.idx == IDX_W'(2)) begin
        head_d[2] = entry_i.id;
      end
    end
  end

  // Pass state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q <= 1'b0;
    end else begin
      dup_q <= dup_d;
    end
  end

  // Accumulated values carry no reset.
  always_ff @(posedge clk_i) begin
    total_q      <= total_d;
    newest_idx_q <= newest_idx_d;
    newest_id_q  <= newest_id_d;
    best_idx_q   <= best_idx_d;
    best_id_q    <= best_id_d;
    best_prog_q  <= best_prog_d;
    head_q       <= head_d;
  end

  assign res_o.total      = total_q;
  assign res_o.newest_idx = newest_idx_q;
  assign res_o.best_idx   = best_idx_q;
  assign res_o.dup        = dup_q;
  assign res_o.head_id    = head_q;

endmodule

`default_nettype wire

// File: hw/rtl/pinned_fifo_retention_table.sv
// Flow: a trim pass reads every record once; each eviction adds one compaction sweep and
// a fresh scan pass and, after the first, one output item for the eviction before it.
// Throughput: one item at a time; the record RAM's single read port sets the pace.
// Reset clears the fill count and the output valid flag, sets entry_limit to 16 and
// budget_mb to 64; the record RAM is not cleared and needs no clearing pass.
// Top level of the retention table: sequencer, record RAM and scan unit.
`default_nettype none

module pinned_fifo_retention_table (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire pfrt_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output pfrt_pkg::out_item_t                  out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pfrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pfrt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import pfrt_pkg::*;

  state_e            state_q, state_d;
  scan_kind_e        kind_q, kind_d;
  in_item_t          item_q, item_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [BUDGET_W-1:0] budget_q;
  logic [CNT_W-1:0]  ra_q, ra_d;
  logic              rv_q, rv_d;
  logic [IDX_W-1:0]  ri_q, ri_d;
  logic              pend_q, pend_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic [ID_W-1:0]   vict_id_q, vict_id_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic              ram_re, ram_we;
  logic [IDX_W-1:0]  ram_raddr, ram_waddr;
  entry_t            ram_wdata, ram_rdata;
  scan_ctrl_t        scan_ctrl;
  scan_res_t         scan_res;

  logic              rd_more, sweep_done, slot_free, insert_ok, over;
  logic [IDX_W-1:0]  victim;
  logic [SIZE_W-1:0] budget_bytes;
  logic [31:0]       limit_raw;

  pfrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfrt_scan_unit u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .summaries_i (item_q.summary_count),
    .probe_id_i  (item_q.record_id),
    .entry_i     (ram_rdata),
    .res_o       (scan_res)
  );

  // Shared status terms.
  assign rd_more    = (ra_q < fill_q);
  assign sweep_done = !rd_more && !rv_q;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign insert_ok  = (in_data_i.record_id != '0) &&
                      (in_data_i.progress <= PROG_W'(PROGRESS_MAX)) &&
                      (in_data_i.frame_count != '0) &&
                      (fill_q < CNT_W'(DEPTH));
  assign budget_bytes = SIZE_W'(budget_q) << MIB_SHIFT;
  assign over = (fill_q > CNT_W'(MIN_KEPT)) &&
                ((fill_q > CNT_W'(limit_q)) || (scan_res.total > budget_bytes));

  // Oldest record that is neither the newest id nor the best progress.
  always_comb begin
    if ((scan_res.newest_idx != IDX_W'(0)) && (scan_res.best_idx != IDX_W'(0))) begin
      victim = IDX_W'(0);
    end else if ((scan_res.newest_idx != IDX_W'(1)) &&
                 (scan_res.best_idx != IDX_W'(1))) begin
      victim = IDX_W'(1);
    end else begin
      victim = IDX_W'(2);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if ((in_data_i.mode == MODE_INSERT) && !insert_ok) begin
            state_d = ST_PUSH_LAST;
          end else begin
            state_d = ST_SCAN_INIT;
          end
        end
      end
      ST_SCAN_INIT: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sweep_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (kind_q == KIND_DUP) begin
          state_d = scan_res.dup ? ST_PUSH_LAST : ST_SCAN_INIT;
        end else if (over) begin
          state_d = pend_q ? ST_PUSH_MID : ST_COMPACT;
        end else begin
          state_d = ST_PUSH_LAST;
        end
      end
      ST_PUSH_MID: begin
        if (slot_free) begin
          state_d = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        if (sweep_done) begin
          state_d = ST_SCAN_INIT;
        end
      end
      ST_PUSH_LAST: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath control per state.
  always_comb begin
    kind_d      = kind_q;
    item_d      = item_q;
    fill_d      = fill_q;
    ra_d        = ra_q;
    rv_d        = 1'b0;
    ri_d        = ri_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    vict_id_d   = vict_id_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    ram_re      = 1'b0;
    ram_raddr   = ra_q[IDX_W-1:0];
    ram_we      = 1'b0;
    ram_waddr   = ri_q - IDX_W'(1);
    ram_wdata   = ram_rdata;
    scan_ctrl   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          kind_d = (in_data_i.mode == MODE_INSERT) ? KIND_DUP : KIND_TRIM;
        end
      end
      ST_SCAN_INIT: begin
        scan_ctrl.start = 1'b1;
        ra_d            = '0;
      end
      ST_SCAN: begin
        // Issue one read a cycle; the scan unit takes each read's data in the next cycle.
        if (rd_more) begin
          ram_re = 1'b1;
          ra_d   = ra_q + CNT_W'(1);
          rv_d   = 1'b1;
          ri_d   = ra_q[IDX_W-1:0];
        end
        scan_ctrl.en  = rv_q;
        scan_ctrl.idx = ri_q;
      end
      ST_DECIDE: begin
        if (kind_q == KIND_DUP) begin
          // Append the new record behind the last one.
          if (!scan_res.dup) begin
            ram_we    = 1'b1;
            ram_waddr = fill_q[IDX_W-1:0];
            ram_wdata = '{id: item_q.record_id, progress: item_q.progress,
                          frames: item_q.frame_count};
            fill_d    = fill_q + CNT_W'(1);
            kind_d    = KIND_TRIM;
          end
        end else if (over) begin
          vict_id_d = scan_res.head_id[victim[1:0]];
          ra_d      = CNT_W'(victim) + CNT_W'(1);
        end
      end
      ST_PUSH_MID: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{evicted_id: pend_id_q, last: 1'b0};
        end
      end
      ST_COMPACT: begin
        // Move every record behind the victim one slot toward the head.
        if (rd_more) begin
          ram_re = 1'b1;
          ra_d   = ra_q + CNT_W'(1);
          rv_d   = 1'b1;
          ri_d   = ra_q[IDX_W-1:0];
        end
        if (rv_q) begin
          ram_we = 1'b1;
        end
        if (sweep_done) begin
          fill_d    = fill_q - CNT_W'(1);
          pend_d    = 1'b1;
          pend_id_d = vict_id_q;
        end
      end
      ST_PUSH_LAST: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{evicted_id: (pend_q ? pend_id_q : '0), last: 1'b1};
          pend_d      = 1'b0;
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Entry limit write value, clamped to the supported range.
  assign limit_raw = 32'(cfg_wdata_i[LIMIT_IN_W-1:0]);

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_TRIM;
      fill_q      <= '0;
      ra_q        <= '0;
      rv_q        <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= LIMIT_W'(LIMIT_RESET);
      budget_q    <= BUDGET_W'(BUDGET_RESET);
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      fill_q      <= fill_d;
      ra_q        <= ra_d;
      rv_q        <= rv_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENTRY_LIMIT: begin
            if (limit_raw == 32'd0) begin
              limit_q <= LIMIT_W'(1);
            end else if (limit_raw > 32'(MAX_ENTRIES)) begin
              limit_q <= LIMIT_W'(MAX_ENTRIES);
            end else begin
              limit_q <= LIMIT_W'(limit_raw);
            end
          end
          CFG_BUDGET_MB: begin
            budget_q <= (cfg_wdata_i[BUDGET_W-1:0] == '0) ? BUDGET_W'(1)
                                                           : cfg_wdata_i[BUDGET_W-1:0];
          end
          default: begin
            budget_q <= budget_q;
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ri_q       <= ri_d;
    pend_id_q  <= pend_id_d;
    vict_id_q  <= vict_id_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/pfrt_checker.sv
// Port-level checker of the retention table and its bind.
`default_nettype none

`include "pinned_fifo_retention_table_assert.svh"

module pfrt_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire pfrt_pkg::out_item_t             out_data_o
);

  // A waiting result is held until taken.
  `PFRT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `PFRT_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o))

  // A result without an evicted record always closes its request.
  `PFRT_ASSERT(a_zero_is_last, out_valid_o && (out_data_o.evicted_id == '0) |-> out_data_o.last)

  // The block is busy in the cycle after it takes a request.
  `PFRT_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)

endmodule

bind pinned_fifo_retention_table pfrt_checker u_pfrt_checker (.*);

`default_nettype wire

// File: dv/tb_pinned_fifo_retention_table.sv
// Self-checking testbench of the retention table: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_pinned_fifo_retention_table;
  import pfrt_pkg::*;

  localparam int unsigned IDLE_LIMIT     = 5000;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned END_CYCLES     = 40;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS    = 50;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned FRAMES_PER_MIB = 10082;
  localparam int unsigned FRAME_MAX      = (1 << FRAME_BITS) - 1;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_SLOW
  } rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Shadow copy of the table and its registers.
  logic [ID_W-1:0]       tbl_id     [DEPTH];
  logic [PROG_W-1:0]     tbl_prog   [DEPTH];
  logic [FRAME_BITS-1:0] tbl_frames [DEPTH];
  int unsigned           tbl_fill;
  int unsigned           cur_limit;
  longint unsigned       cur_budget_mb;

  out_item_t             pending_evictions [$];
  out_item_t             head_result;
  int unsigned           mismatch_count;
  int unsigned           quiet_cycles;
  logic [ID_W-1:0]       next_id;

  pinned_fifo_retention_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Append one expected result behind the ones already queued.
  task automatic queue_result(input out_item_t res);
    pending_evictions = {pending_evictions, res};
  endtask

  // Apply one request to the shadow table and queue the evictions it causes.
  task automatic predict_evictions(input in_item_t req);
    int              newest;
    int              best;
    int              victim;
    int              n;
    bit              ok;
    longint unsigned total;
    longint unsigned budget_bytes;
    out_item_t       res;
    n = 0;
    if (req.mode == MODE_INSERT) begin
      ok = (req.record_id != '0) && (req.progress <= PROGRESS_MAX) &&
           (req.frame_count != '0) && (tbl_fill < DEPTH);
      for (int i = 0; i < tbl_fill; i++) begin
        if (tbl_id[i] == req.record_id) ok = 1'b0;
      end
      if (!ok) begin
        res.evicted_id = '0;
        res.last       = 1'b1;
        queue_result(res);
        return;
      end
      tbl_id[tbl_fill]     = req.record_id;
      tbl_prog[tbl_fill]   = req.progress;
      tbl_frames[tbl_fill] = req.frame_count;
      tbl_fill++;
    end
    budget_bytes = cur_budget_mb << MIB_SHIFT;
    while (tbl_fill > MIN_KEPT && n < DEPTH) begin
      total = BASE_BYTES + 64'(SUMMARY_BYTES) * 64'(req.summary_count);
      for (int i = 0; i < tbl_fill; i++) begin
        total += RECORD_BYTES + 64'(FRAME_BYTES) * 64'(tbl_frames[i]);
      end
      if (!(tbl_fill > cur_limit || total > budget_bytes)) break;
      // The highest id and the best progress (ties to the larger id) are kept.
      newest = 0;
      best   = 0;
      for (int i = 1; i < tbl_fill; i++) begin
        if (tbl_id[i] > tbl_id[newest]) newest = i;
        if (tbl_prog[i] > tbl_prog[best] ||
            (tbl_prog[i] == tbl_prog[best] && tbl_id[i] > tbl_id[best])) best = i;
      end
      victim = -1;
      for (int i = 0; i < tbl_fill; i++) begin
        if (victim < 0 && tbl_id[i] != tbl_id[newest] && tbl_id[i] != tbl_id[best]) victim = i;
      end
      if (victim < 0) break;
      res.evicted_id = tbl_id[victim];
      res.last       = 1'b0;
      queue_result(res);
      for (int i = victim; i + 1 < tbl_fill; i++) begin
        tbl_id[i]     = tbl_id[i + 1];
        tbl_prog[i]   = tbl_prog[i + 1];
        tbl_frames[i] = tbl_frames[i + 1];
      end
      tbl_fill--;
      n++;
    end
    if (n == 0) begin
      res.evicted_id = '0;
      res.last       = 1'b1;
      queue_result(res);
    end else begin
      pending_evictions[pending_evictions.size() - 1].last = 1'b1;
    end
  endtask

  function automatic in_item_t make_request(input logic mode, input logic [ID_W-1:0] id,
                                            input int unsigned prog, input int unsigned frames,
                                            input int unsigned summ);
    in_item_t req;
    req.mode          = mode;
    req.record_id     = id;
    req.progress      = prog[PROG_W-1:0];
    req.frame_count   = frames[FRAME_BITS-1:0];
    req.summary_count = summ[SUMM_W-1:0];
    return req;
  endfunction

  function automatic logic [ID_W-1:0] rand_id64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed inserts with rising ids, plus duplicates, zero ids, bad fields and trims.
  function automatic in_item_t random_request(input int unsigned frame_hi);
    int unsigned     pick;
    logic [ID_W-1:0] id;
    int unsigned     prog;
    int unsigned     frames;
    int unsigned     summ;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      next_id = next_id + 1 + (rand_id64() >> $urandom_range(8, 63));
      id      = next_id;
    end else if (pick < 80) begin
      id = rand_id64();
    end else if (pick < 88 && tbl_fill > 0) begin
      id = tbl_id[$urandom_range(0, tbl_fill - 1)];
    end else if (pick < 92) begin
      id = '0;
    end else begin
      id = (rand_id64() % next_id) + 1;
    end
    pick = $urandom_range(0, 99);
    if (pick < 45)      prog = $urandom_range(0, PROGRESS_MAX);
    else if (pick < 75) prog = $urandom_range(0, 4) * 2500;
    else if (pick < 92) prog = $urandom_range(0, 200);
    else                prog = $urandom_range(PROGRESS_MAX + 1, (1 << PROG_W) - 1);
    pick = $urandom_range(0, 99);
    if (pick < 4)       frames = 0;
    else if (pick < 12) frames = $urandom_range(1, FRAME_MAX);
    else                frames = $urandom_range(1, frame_hi);
    if ($urandom_range(0, 9) == 0) summ = $urandom_range(0, (1 << SUMM_W) - 1);
    else                           summ = $urandom_range(0, 64);
    return make_request(($urandom_range(0, 99) < 85) ? MODE_INSERT : MODE_TRIM,
                        id, prog, frames, summ);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input in_item_t req);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = req;
    do @(posedge clk_i); while (!in_ready_o);
    predict_evictions(req);
  endtask

  task automatic sender_pause(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop sending until every queued result has come back, then let the block settle.
  task automatic drain_results(input int unsigned extra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_evictions.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Registers are only written once the block has gone idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    logic [LIMIT_IN_W-1:0] lim;
    drain_results(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_ENTRY_LIMIT) begin
      lim       = value[LIMIT_IN_W-1:0];
      cur_limit = (lim < 1) ? 1 : ((lim > MAX_ENTRIES) ? MAX_ENTRIES : lim);
    end else begin
      cur_budget_mb = (value == '0) ? 1 : value;
    end
  endtask

  // Reset values: a huge first record pushes the size estimate past 64 MiB.
  task automatic test_default_config();
    send_request(make_request(MODE_INSERT, '1, 0, FRAME_MAX, (1 << SUMM_W) - 1));
    send_request(make_request(MODE_INSERT, 64'd1, PROGRESS_MAX, 1, 0));
    send_request(make_request(MODE_INSERT, 64'd2, 5000, 1, 0));
    send_request(make_request(MODE_TRIM, 64'd0, 0, 0, 0));
  endtask

  // Zero id, duplicate id, progress out of range and zero frames are all refused.
  task automatic test_rejected_inserts();
    send_request(make_request(MODE_INSERT, 64'd0, 100, 5, 0));
    send_request(make_request(MODE_INSERT, 64'd1, 100, 5, 0));
    send_request(make_request(MODE_INSERT, 64'd3, PROGRESS_MAX + 1, 5, 0));
    send_request(make_request(MODE_INSERT, 64'd4, (1 << PROG_W) - 1, 5, 0));
    send_request(make_request(MODE_INSERT, 64'd5, 100, 0, 0));
  endtask

  // Entry limit clamping, a progress tie, and a trim that evicts several records.
  task automatic test_entry_limit_clamp();
    write_register(CFG_ENTRY_LIMIT, 16'd0);
    write_register(CFG_BUDGET_MB, 16'hFFFF);
    send_request(make_request(MODE_INSERT, 64'd100, 3000, 1, 0));
    send_request(make_request(MODE_INSERT, 64'd101, PROGRESS_MAX, 1, 0));
    write_register(CFG_ENTRY_LIMIT, 16'd31);
    for (int k = 0; k < 6; k++) begin
      send_request(make_request(MODE_INSERT, 64'd200 + k, 1000 * k, 1 + k, 0));
    end
    write_register(CFG_ENTRY_LIMIT, 16'd3);
    send_request(make_request(MODE_TRIM, rand_id64(), 0, 0, 0));
  endtask

  // Smallest byte budget: summaries alone or one big record overflow it.
  task automatic test_byte_budget();
    write_register(CFG_ENTRY_LIMIT, 16'd16);
    write_register(CFG_BUDGET_MB, 16'd0);
    send_request(make_request(MODE_TRIM, 64'd0, 0, 0, (1 << SUMM_W) - 1));
    send_request(make_request(MODE_INSERT, 64'd300, 0, FRAME_MAX, 0));
  endtask

  // Phases of random traffic, each under its own register setting.
  task automatic test_random_traffic();
    int unsigned limit_raw;
    int unsigned budget_raw;
    int unsigned frame_hi;
    int unsigned burst_left;
    bit          idle_en;
    burst_left = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          limit_raw  = 31;
          budget_raw = 16'hFFFF;
        end
        1: begin
          limit_raw  = 1;
          budget_raw = 1;
        end
        2: begin
          limit_raw  = 0;
          budget_raw = 0;
        end
        default: begin
          limit_raw  = $urandom_range(0, 16'hFFFF);
          budget_raw = $urandom_range(0, 1) ? $urandom_range(0, 16'hFFFF) : $urandom_range(1, 6);
        end
      endcase
      write_register(CFG_ENTRY_LIMIT, limit_raw[CFG_DATA_W-1:0]);
      write_register(CFG_BUDGET_MB, budget_raw[CFG_DATA_W-1:0]);
      // Size the frames so a handful of records fill the budget.
      frame_hi = (int'(cur_budget_mb) * FRAMES_PER_MIB) / 3;
      if (frame_hi > FRAME_MAX) frame_hi = FRAME_MAX;
      idle_en = (p % 3) != 1;
      // A trim right after the register change re-runs eviction.
      send_request(make_request(MODE_TRIM, rand_id64(), $urandom_range(0, (1 << PROG_W) - 1),
                                $urandom_range(0, FRAME_MAX), $urandom_range(0, 255)));
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain_results(0);
        if (idle_en && burst_left == 0) begin
          if ($urandom_range(0, 9) == 0) sender_pause($urandom_range(20, 60));
          else                           sender_pause($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end
        send_request(random_request(frame_hi));
        if (burst_left > 0) burst_left--;
      end
    end
  endtask

  // Receiver: switches between always ready, coin toss, a fixed pattern and slow draining.
  initial begin
    int unsigned      stall_left;
    int unsigned      pat_pos;
    logic [11:0]      pattern;
    rx_mode_e         rx_mode;
    out_ready_i = 1'b0;
    stall_left  = 0;
    pat_pos     = 0;
    pattern     = '1;
    rx_mode     = RX_OPEN;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 3));
        pattern    = 12'($urandom_range(1, 4095));
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      case (rx_mode)
        RX_OPEN:    out_ready_i = 1'b1;
        RX_COIN:    out_ready_i = 1'($urandom_range(0, 1));
        RX_PATTERN: begin
          out_ready_i = pattern[pat_pos];
          pat_pos     = (pat_pos + 1) % 12;
        end
        default:    out_ready_i = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest queued one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_evictions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("ERROR: unexpected result evicted_id=%h last=%b",
                   out_data_o.evicted_id, out_data_o.last);
        end
      end else begin
        head_result = pending_evictions.pop_front();
        if (out_data_o.evicted_id !== head_result.evicted_id ||
            out_data_o.last !== head_result.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR: evicted_id exp %h got %h, last exp %b got %b",
                     head_result.evicted_id, out_data_o.evicted_id,
                     head_result.last, out_data_o.last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("pinned_fifo_retention_table verification failed");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    tbl_fill       = 0;
    cur_limit      = LIMIT_RESET;
    cur_budget_mb  = BUDGET_RESET;
    next_id        = 64'd4096;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_config();
    test_rejected_inserts();
    test_entry_limit_clamp();
    test_byte_budget();
    test_random_traffic();
    drain_results(END_CYCLES);

    if (mismatch_count == 0 && pending_evictions.size() == 0) begin
      $display("pinned_fifo_retention_table verification clean");
    end else begin
      $display("pinned_fifo_retention_table verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/pfrt_pkg.sv
hw/rtl/pfrt_ram.sv
hw/rtl/pfrt_scan_unit.sv
hw/rtl/pinned_fifo_retention_table.sv
hw/rtl/pfrt_checker.sv
dv/tb_pinned_fifo_retention_table.sv
